FILE: rtl/tet_pkg.sv
// ----------------------------------------------------------------------------
// tet_pkg
// Types and constants shared by the timer expiry table modules.
// ----------------------------------------------------------------------------
package tet_pkg;

  localparam int MaxTimers = 16;
  localparam int SlotW     = $clog2(MaxTimers);

  localparam logic [1:0] OP_ADD    = 2'd0;
  localparam logic [1:0] OP_CANCEL = 2'd1;
  localparam logic [1:0] OP_CHECK  = 2'd2;
  localparam logic [1:0] OP_NOP    = 2'd3;

  localparam logic [2:0] ST_ADDED    = 3'd0;
  localparam logic [2:0] ST_FULL     = 3'd1;
  localparam logic [2:0] ST_CANCELED = 3'd2;
  localparam logic [2:0] ST_NOTFOUND = 3'd3;
  localparam logic [2:0] ST_FIRED    = 3'd4;
  localparam logic [2:0] ST_WAIT     = 3'd5;

  typedef struct packed {
    logic [1:0]  operation;
    logic [47:0] now_ms;
    logic [30:0] timeout_ms;
    logic [31:0] cancel_id;
    logic [15:0] event_tag;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] timer_ident;
    logic [15:0] fired_tag;
    logic [47:0] wait_ms;
    logic        last;
  } out_item_t;

  // controller -> datapath
  typedef struct packed {
    logic load;      // capture input item
    logic scan_clr;  // reset scan pointer and best
    logic scan_step; // examine one slot
    logic do_add;
    logic do_cancel;
    logic do_fire;   // remove best due entry and emit
    logic emit_wait; // emit next wait
    logic emit_resp; // emit add/cancel response
  } tet_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic scan_done;
    logic have_due;
    logic out_busy;
  } tet_sts_t;

endpackage

FILE: rtl/tet_ctrl.sv
// ----------------------------------------------------------------------------
// tet_ctrl
// Sequencer: accepts one item, runs slot scans and steers result emission.
// ----------------------------------------------------------------------------
module tet_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  logic [1:0]      in_op,
  output logic            in_stall,
  output tet_pkg::tet_cmd_t cmd,
  input  tet_pkg::tet_sts_t sts
);
  import tet_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SCAN = 3'd1;
  localparam logic [2:0] S_FIRE = 3'd2;
  localparam logic [2:0] S_WSCN = 3'd3;
  localparam logic [2:0] S_WEMT = 3'd4;
  localparam logic [2:0] S_RESP = 3'd5;

  logic [2:0] state_r, state_nxt;
  logic [1:0] op_r, op_nxt;

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    op_nxt    = op_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid && (in_op == OP_ADD || in_op == OP_CANCEL || in_op == OP_CHECK)) begin
          cmd.load     = 1'b1;
          cmd.scan_clr = 1'b1;
          op_nxt       = in_op;
          state_nxt    = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.scan_done) begin
          state_nxt = (op_r == OP_CHECK) ? S_FIRE : S_RESP;
        end
      end
      S_FIRE: begin
        if (!sts.out_busy) begin
          cmd.scan_clr = 1'b1;
          if (sts.have_due) begin
            cmd.do_fire = 1'b1;
            state_nxt   = S_SCAN;
          end else begin
            state_nxt = S_WSCN;
          end
        end
      end
      S_WSCN: begin
        cmd.scan_step = 1'b1;
        if (sts.scan_done) state_nxt = S_WEMT;
      end
      S_WEMT: begin
        if (!sts.out_busy) begin
          cmd.emit_wait = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      S_RESP: begin
        if (!sts.out_busy) begin
          cmd.emit_resp = 1'b1;
          cmd.do_add    = (op_r == OP_ADD);
          cmd.do_cancel = (op_r == OP_CANCEL);
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      op_r    <= OP_ADD;
    end else begin
      state_r <= state_nxt;
      op_r    <= op_nxt;
    end
  end

`ifndef ASSERT_OFF
  a_one_emit: assert property (@(posedge clk) disable iff (!rst_n)
    $countones({cmd.do_fire, cmd.emit_wait, cmd.emit_resp}) <= 1)
    else $error("more than one emit command");
  a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |-> state_r == S_IDLE)
    else $error("load outside idle");
  a_load_scan: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> state_r == S_SCAN)
    else $error("load not followed by scan");
`endif

endmodule

FILE: rtl/tet_dpath.sv
// ----------------------------------------------------------------------------
// tet_dpath
// Timer table, per-slot scan unit and result register.
// ----------------------------------------------------------------------------
module tet_dpath (
  input  logic              clk,
  input  logic              rst_n,
  input  tet_pkg::in_item_t in_data,
  input  tet_pkg::tet_cmd_t cmd,
  output tet_pkg::tet_sts_t sts,
  output logic              out_valid,
  input  logic              out_stall,
  output tet_pkg::out_item_t out_data
);
  import tet_pkg::*;

  logic [MaxTimers-1:0] valid_r, valid_nxt;
  logic [47:0] exp_r [MaxTimers];
  logic [31:0] id_r  [MaxTimers];
  logic [15:0] tag_r [MaxTimers];
  logic [31:0] last_id_r;

  in_item_t   item_r;
  logic [SlotW:0]   ptr_r;
  logic [SlotW-1:0] idx;
  logic             done;

  // scan results
  logic             fnd_r;   // free slot / matching id found
  logic [SlotW-1:0] fslot_r;
  logic             due_r;
  logic [SlotW-1:0] dslot_r;
  logic [47:0]      dexp_r;
  logic [31:0]      did_r;
  logic             pend_r;
  logic [47:0]      pexp_r;

  logic      out_valid_r;
  out_item_t out_r;

  logic [48:0] sum;
  logic [47:0] exp_add;

  assign idx  = ptr_r[SlotW-1:0];
  assign done = (ptr_r == (SlotW+1)'(MaxTimers - 1));
  assign sum  = {1'b0, item_r.now_ms} + {18'd0, item_r.timeout_ms};
  assign exp_add = sum[48] ? '1 : sum[47:0];

  assign sts.scan_done = done;
  assign sts.have_due  = due_r;
  assign sts.out_busy  = out_valid_r && out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_comb begin
    valid_nxt = valid_r;
    if (cmd.do_add && fnd_r) valid_nxt[fslot_r] = 1'b1;
    if (cmd.do_cancel && fnd_r) valid_nxt[fslot_r] = 1'b0;
    if (cmd.do_fire) valid_nxt[dslot_r] = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r     <= '0;
      last_id_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      if (cmd.do_add && fnd_r) last_id_r <= last_id_r + 32'd1;
      if (cmd.do_fire || cmd.emit_wait || cmd.emit_resp) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (cmd.load) item_r <= in_data;
    if (cmd.do_add && fnd_r) begin
      exp_r[fslot_r] <= exp_add;
      id_r[fslot_r]  <= last_id_r + 32'd1;
      tag_r[fslot_r] <= item_r.event_tag;
    end
    if (cmd.scan_clr) begin
      ptr_r  <= '0;
      fnd_r  <= 1'b0;
      due_r  <= 1'b0;
      pend_r <= 1'b0;
    end else if (cmd.scan_step) begin
      if (!done) ptr_r <= ptr_r + (SlotW+1)'(1);
      if (valid_r[idx]) begin
        if (!pend_r || exp_r[idx] < pexp_r) begin
          pend_r <= 1'b1;
          pexp_r <= exp_r[idx];
        end
        if (exp_r[idx] <= item_r.now_ms && (!due_r || exp_r[idx] < dexp_r ||
            (exp_r[idx] == dexp_r && id_r[idx] < did_r))) begin
          due_r   <= 1'b1;
          dslot_r <= idx;
          dexp_r  <= exp_r[idx];
          did_r   <= id_r[idx];
        end
      end
      // add: lowest free slot; cancel: lowest matching slot
      if (!fnd_r) begin
        if (item_r.operation == OP_ADD) begin
          if (!valid_r[idx]) begin
            fnd_r <= 1'b1; fslot_r <= idx;
          end
        end else if (valid_r[idx] && id_r[idx] == item_r.cancel_id) begin
          fnd_r <= 1'b1; fslot_r <= idx;
        end
      end
    end
    if (cmd.do_fire) begin
      out_r <= '{ST_FIRED, did_r, tag_r[dslot_r], 48'd0, 1'b0};
    end else if (cmd.emit_wait) begin
      out_r <= '{ST_WAIT, 32'd0, 16'd0, pend_r ? pexp_r - item_r.now_ms : 48'd0, 1'b1};
    end else if (cmd.emit_resp) begin
      if (item_r.operation == OP_ADD) begin
        // note fnd_r means a free slot was found for an add
        if (fnd_r) out_r <= '{ST_ADDED, last_id_r + 32'd1, 16'd0, 48'd0, 1'b1};
        else out_r <= '{ST_FULL, 32'd0, 16'd0, 48'd0, 1'b1};
      end else begin
        out_r <= '{fnd_r ? ST_CANCELED : ST_NOTFOUND, item_r.cancel_id,
                   16'd0, 48'd0, 1'b1};
      end
    end
  end

`ifndef ASSERT_OFF
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |-> !(cmd.do_fire || cmd.emit_wait || cmd.emit_resp))
    else $error("result overwritten while stalled");
  a_fire_due: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.do_fire |-> due_r && valid_r[dslot_r])
    else $error("fire without due entry");
  a_fire_clr: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.do_fire |=> !valid_r[$past(dslot_r)])
    else $error("fired entry not removed");
`endif

endmodule

FILE: rtl/timer_expiry_table.sv
// ----------------------------------------------------------------------------
// timer_expiry_table
// Table of one-shot timers with add, cancel and expiry check.
// ----------------------------------------------------------------------------
// One item at a time. Each slot scan examines one table slot (16) per cycle:
// add and cancel run one scan and then respond; a check scans and fires the
// earliest due timer until a scan finds nothing more due, then runs a final
// next-wait scan, all on the single slot-compare unit. Results leave
// through an output register; each transaction's final result carries last.
module timer_expiry_table (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  tet_pkg::in_item_t   in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output tet_pkg::out_item_t  out_data
);
  import tet_pkg::*;

  tet_cmd_t cmd;
  tet_sts_t sts;

  tet_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_op(in_data.operation), .in_stall, .cmd, .sts
  );

  tet_dpath u_dpath (
    .clk, .rst_n, .in_data, .cmd, .sts, .out_valid, .out_stall, .out_data
  );

endmodule

FILE: tb/sv/timer_expiry_table_chk.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// timer_expiry_table_chk
// Watches both channels of the timer expiry table, keeps its own copy of the
// timer table, works out the results of every accepted transaction and
// compares them field by field with what the block emits.
// ----------------------------------------------------------------------------
module timer_expiry_table_chk (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_stall,
  input  tet_pkg::in_item_t   in_data,
  input  logic                out_valid,
  input  logic                out_stall,
  input  tet_pkg::out_item_t  out_data,
  output int                  fail_count,
  output int                  pending
);
  import tet_pkg::*;

  logic        tmr_valid [MaxTimers];
  logic [47:0] tmr_expiry[MaxTimers];
  logic [31:0] tmr_ident [MaxTimers];
  logic [15:0] tmr_tag   [MaxTimers];
  logic [31:0] ident_ctr;
  out_item_t   result_q[$];

  function automatic out_item_t make_result(logic [2:0] st, logic [31:0] id,
                                            logic [15:0] tg, logic [47:0] w,
                                            logic fin);
    out_item_t r;
    r.status = st; r.timer_ident = id; r.fired_tag = tg;
    r.wait_ms = w; r.last = fin;
    return r;
  endfunction

  task automatic predict_table(input in_item_t it);
    int          slot;
    int          b;
    logic [48:0] sum;
    logic [47:0] best;
    logic        have;
    slot = -1;
    case (it.operation)
      OP_ADD: begin
        for (int i = 0; i < MaxTimers; i++)
          if (!tmr_valid[i] && slot < 0) slot = i;
        if (slot < 0) begin
          result_q.push_back(make_result(ST_FULL, '0, '0, '0, 1'b1));
        end else begin
          sum = {1'b0, it.now_ms} + {18'd0, it.timeout_ms};
          ident_ctr = ident_ctr + 32'd1;
          tmr_valid[slot]  = 1'b1;
          tmr_expiry[slot] = sum[48] ? 48'hFFFF_FFFF_FFFF : sum[47:0];
          tmr_ident[slot]  = ident_ctr;
          tmr_tag[slot]    = it.event_tag;
          result_q.push_back(make_result(ST_ADDED, ident_ctr, '0, '0, 1'b1));
        end
      end
      OP_CANCEL: begin
        for (int i = 0; i < MaxTimers; i++)
          if (slot < 0 && tmr_valid[i] && tmr_ident[i] == it.cancel_id) slot = i;
        if (slot >= 0) tmr_valid[slot] = 1'b0;
        result_q.push_back(make_result(slot >= 0 ? ST_CANCELED : ST_NOTFOUND,
                                       it.cancel_id, '0, '0, 1'b1));
      end
      OP_CHECK: begin
        // emit due timers, earliest first, lower id on ties
        do begin
          b = -1;
          for (int i = 0; i < MaxTimers; i++) begin
            if (tmr_valid[i] && tmr_expiry[i] <= it.now_ms &&
                (b < 0 || tmr_expiry[i] < tmr_expiry[b] ||
                 (tmr_expiry[i] == tmr_expiry[b] && tmr_ident[i] < tmr_ident[b])))
              b = i;
          end
          if (b >= 0) begin
            tmr_valid[b] = 1'b0;
            result_q.push_back(make_result(ST_FIRED, tmr_ident[b], tmr_tag[b],
                                           '0, 1'b0));
          end
        end while (b >= 0);
        have = 1'b0;
        best = '0;
        for (int i = 0; i < MaxTimers; i++)
          if (tmr_valid[i] && (!have || tmr_expiry[i] < best)) begin
            best = tmr_expiry[i];
            have = 1'b1;
          end
        result_q.push_back(make_result(ST_WAIT, '0, '0,
                                       have ? best - it.now_ms : 48'd0, 1'b1));
      end
      default: ;
    endcase
  endtask

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("%0t: %s mismatch: got %0h, expected %0h", $realtime, what, got, want);
    fail_count++;
  endtask

  assign pending = result_q.size();

  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      for (int i = 0; i < MaxTimers; i++) tmr_valid[i] = 1'b0;
      ident_ctr = '0;
      result_q.delete();
      fail_count = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (result_q.size() == 0) begin
          $display("%0t: result with no transaction waiting for it", $realtime);
          fail_count++;
        end else begin
          want = result_q.pop_front();
          if (out_data.status != want.status)
            report_mismatch("status", 64'(out_data.status), 64'(want.status));
          if (out_data.timer_ident != want.timer_ident)
            report_mismatch("timer_ident", 64'(out_data.timer_ident),
                            64'(want.timer_ident));
          if (out_data.fired_tag != want.fired_tag)
            report_mismatch("fired_tag", 64'(out_data.fired_tag),
                            64'(want.fired_tag));
          if (out_data.wait_ms != want.wait_ms)
            report_mismatch("wait_ms", 64'(out_data.wait_ms), 64'(want.wait_ms));
          if (out_data.last != want.last)
            report_mismatch("last", 64'(out_data.last), 64'(want.last));
        end
      end
      if (in_valid && !in_stall) predict_table(in_data);
    end
  end

endmodule

FILE: tb/sv/timer_expiry_table_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// timer_expiry_table_tb
// Drives adds, cancels and expiry checks into the timer expiry table, with
// random idle bursts on both sides and one long output hold-off; the checker
// beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module timer_expiry_table_tb;
  import tet_pkg::*;

  localparam int WatchdogLimit = 20000;
  localparam int HoldOffCycles = 400;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;
  int        fail_count;
  int        pending;
  bit        quiet_phase = 1'b0;
  bit        hold_req = 1'b0;
  int        idle_cycles = 0;
  logic [47:0] now_base = 48'd1000;
  logic [31:0] ident_seen = 32'd0;

  always #2 clk = ~clk;

  timer_expiry_table dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  timer_expiry_table_chk chk (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .fail_count(fail_count), .pending(pending)
  );

  // track recent ids so cancels often hit live timers
  always @(posedge clk)
    if (out_valid && !out_stall && out_data.status == ST_ADDED)
      ident_seen <= out_data.timer_ident;

  // receiver: random stall bursts, or a long hold-off on request
  initial begin
    int n;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        for (int i = 0; i < HoldOffCycles; i++) @(posedge clk);
        out_stall <= 1'b0;
        hold_req = 1'b0;
      end else if (!quiet_phase && $urandom_range(0, 5) == 0) begin
        n = $urandom_range(1, 3);
        out_stall <= 1'b1;
        for (int i = 0; i < n; i++) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WatchdogLimit) begin
      $display("timer_expiry_table_tb NOT OK");
      $finish;
    end
  end

  // valid stays high into the next transaction unless an idle burst follows
  task automatic send_item(input logic [1:0] op, input logic [47:0] now,
                           input logic [30:0] tmo, input logic [31:0] cid,
                           input logic [15:0] tg);
    int gap;
    if (!quiet_phase && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 3);
      in_valid <= 1'b0;
      for (int i = 0; i < gap; i++) @(posedge clk);
    end
    in_data  <= '{operation: op, now_ms: now, timeout_ms: tmo,
                  cancel_id: cid, event_tag: tg};
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic random_item();
    int          sel;
    logic [47:0] now;
    sel = $urandom_range(0, 99);
    now_base = now_base + $urandom_range(0, 40);
    now = now_base;
    if (sel < 45)
      send_item(OP_ADD, now, ($urandom_range(0, 9) == 0) ? 31'($urandom)
                : 31'($urandom_range(0, 120)), 32'($urandom), 16'($urandom));
    else if (sel < 65)
      send_item(OP_CANCEL, now, 31'($urandom), ($urandom_range(0, 3) == 0) ?
                32'($urandom) : ident_seen - 32'($urandom_range(0, 12)),
                16'($urandom));
    else if (sel < 97)
      send_item(OP_CHECK, now, 31'($urandom), 32'($urandom), 16'($urandom));
    else
      send_item(OP_NOP, 48'($urandom) << 16, 31'($urandom), 32'($urandom),
                16'($urandom));
  endtask

  initial begin
    int wait_n;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty check, extremes, saturation, full table, cancels
    send_item(OP_CHECK, 48'd0, '0, '0, '0);
    send_item(OP_ADD, 48'hFFFF_FFFF_FFFF, 31'h7FFF_FFFF, '0, 16'hFFFF);
    send_item(OP_ADD, 48'hFFFF_FFF0_0000, 31'h7FFF_FFFF, '0, 16'h0000);
    send_item(OP_ADD, 48'd0, 31'd0, 32'hFFFF_FFFF, 16'hA5A5);
    send_item(OP_ADD, 48'd0, 31'd0, '0, 16'h5A5A);
    for (int i = 0; i < 13; i++)
      send_item(OP_ADD, 48'd10, 31'(i % 3), '0, 16'(i));
    send_item(OP_CANCEL, '0, '0, 32'd3, '0);
    send_item(OP_CANCEL, '0, '0, 32'd3, '0);
    send_item(OP_CANCEL, '0, '0, 32'hFFFF_FFFF, '0);
    send_item(OP_NOP, 48'hFFFF_FFFF_FFFF, 31'h7FFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF);
    send_item(OP_CHECK, 48'd11, '0, '0, '0);
    send_item(OP_CHECK, 48'hFFFF_FFFF_FFFE, '0, '0, '0);
    send_item(OP_CHECK, 48'hFFFF_FFFF_FFFF, '0, '0, '0);

    // random traffic with a long receiver hold-off partway in
    for (int k = 0; k < 330; k++) begin
      if (k == 60) hold_req = 1'b1;
      if (k == 280) quiet_phase = 1'b1;
      random_item();
    end
    send_item(OP_CHECK, 48'hFFFF_FFFF_FFFF, '0, '0, '0);
    in_valid <= 1'b0;

    wait_n = 0;
    while (pending != 0 && wait_n < 5000) begin
      @(posedge clk);
      wait_n++;
    end
    repeat (40) @(posedge clk);
    if (pending == 0 && fail_count == 0)
      $display("timer_expiry_table_tb OK");
    else
      $display("timer_expiry_table_tb NOT OK");
    $finish;
  end

endmodule
